>>> rtl/pbk_pkg.sv
// Package for the front-panel button and knob controller.
// Holds the shared widths, the debounce patterns, the brightness constants and the knob
// step table. It depends on nothing else.
`default_nettype none

package pbk_pkg;

    // Request kinds carried by the mode field.
    localparam logic MODE_TICK     = 1'b0;
    localparam logic MODE_ROTATION = 1'b1;

    // Knob counter modulus and width.
    localparam int COUNT_MODULUS = 10000;
    localparam int COUNT_W       = 14;
    localparam int DELTA_W       = 5;
    localparam int DELTA_CODES   = 1 << DELTA_W;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [DELTA_CODES-1:0][COUNT_W-1:0] delta_tab_t;

    // Four-sample button history patterns.
    localparam logic [3:0] PRESS_PATTERN   = 4'b0001;
    localparam logic [3:0] RELEASE_PATTERN = 4'b1110;

    // Breath rate shift register.
    localparam int          SHIFT_W     = 5;
    localparam logic [4:0]  SHIFT_RESET = 5'd12;

    // Triangle wave: the distance from mid phase is clamped between two knees.
    localparam logic [5:0] PHASE_MID     = 6'd32;
    localparam logic [5:0] LOW_KNEE      = 6'd9;
    localparam logic [5:0] HIGH_KNEE     = 6'd23;
    localparam logic [5:0] BRIGHT_OFFSET = 6'd8;
    localparam logic [3:0] BRIGHT_MIN    = 4'd1;
    localparam logic [3:0] BRIGHT_MAX    = 4'd15;

    // Each signed step code reduced into the range 0 to COUNT_MODULUS-1.
    // This is evaluated once at elaboration.
    function automatic delta_tab_t build_delta_tab();
        delta_tab_t tab;
        int         step;
        int         rem;
        for (int i = 0; i < DELTA_CODES; i++)
        begin
            step = (i >= DELTA_CODES / 2) ? i - DELTA_CODES : i;
            rem  = step % COUNT_MODULUS;
            if (rem < 0)
            begin
                rem = rem + COUNT_MODULUS;
            end
            tab[i] = count_t'(rem);
        end
        return tab;
    endfunction

    localparam delta_tab_t DELTA_MOD_TAB = build_delta_tab();

endpackage

`default_nettype wire

>>> rtl/panel_button_knob_controller.sv
// Front-panel controller top level: button debounce, load switch, breathing brightness
// and a knob counter. Depends on pbk_pkg for constants and the knob step table.
//
//  Channel   Direction  Handshake                  Payload
//  config    in         cfg_write_en               cfg_write_data (breath rate shift)
//  request   in         in_valid / in_stall        mode, button_level, rotation_delta
//  result    out        out_valid / out_stall      key_held .. count_changed
//
// Each request is first held in the input register, then the state update and result
// are computed into the result register.
// A new request is accepted every cycle while the result side takes its results.
// Reset clears the debounce history, flags, tick and knob counters and sets the shift to 12.
// A stalled result holds in the result register; the input register keeps its request
// and in_stall rises only when both registers are full.
`default_nettype none

module panel_button_knob_controller
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [pbk_pkg::SHIFT_W-1:0]  cfg_write_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         mode,
    input  wire logic                         button_level,
    input  wire logic signed [pbk_pkg::DELTA_W-1:0] rotation_delta,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              key_held,
    output logic                              press_event,
    output logic                              release_event,
    output logic                              switch_on,
    output logic [3:0]                        brightness,
    output logic [pbk_pkg::COUNT_W-1:0]       count_value,
    output logic                              count_changed
);

    // Configuration and state registers.
    logic [pbk_pkg::SHIFT_W-1:0] shift_reg;
    logic [3:0]                  history_reg;
    logic                        held_reg;
    logic                        switch_state_reg;
    logic [31:0]                 tick_reg;
    pbk_pkg::count_t             knob_count_reg;

    // Input register.
    logic                        s1_valid_reg;
    logic                        s1_mode_reg;
    logic                        s1_level_reg;
    logic [pbk_pkg::DELTA_W-1:0] s1_delta_reg;

    // Result register.
    logic                        out_valid_reg;
    logic                        key_held_reg;
    logic                        press_event_reg;
    logic                        release_event_reg;
    logic                        switch_on_reg;
    logic [3:0]                  brightness_reg;
    pbk_pkg::count_t             count_value_reg;
    logic                        count_changed_reg;

    // Handshake.
    logic in_accept;
    logic s2_ready;
    logic s1_fire;

    // Next-state values.
    logic [3:0]      history_next;
    logic            held_next;
    logic            switch_state_next;
    logic [31:0]     tick_next;
    pbk_pkg::count_t knob_count_next;
    logic            press_next;
    logic            release_next;
    logic            changed_next;
    logic [3:0]      brightness_next;

    // Working values.
    logic [pbk_pkg::COUNT_W:0] knob_sum;
    logic [31:0]               tick_shifted;
    logic [5:0]                phase;
    logic [5:0]                phase_dist;

    // The result register frees when empty or when its result is taken.
    assign s2_ready  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && s2_ready;
    assign in_stall  = s1_valid_reg && !s2_ready;
    assign in_accept = in_valid && !in_stall;

    // Button debounce, switch toggle and tick counter.
    always_comb
    begin
        history_next      = history_reg;
        held_next         = held_reg;
        switch_state_next = switch_state_reg;
        tick_next         = tick_reg;
        press_next        = 1'b0;
        release_next      = 1'b0;
        if (s1_mode_reg == pbk_pkg::MODE_TICK)
        begin
            history_next = {history_reg[2:0], ~s1_level_reg};
            if (history_next == pbk_pkg::PRESS_PATTERN)
            begin
                held_next         = 1'b1;
                press_next        = 1'b1;
                switch_state_next = ~switch_state_reg;
            end
            else if (history_next == pbk_pkg::RELEASE_PATTERN)
            begin
                held_next    = 1'b0;
                release_next = 1'b1;
            end
            tick_next = tick_reg + 32'd1;
        end
    end

    // Knob counter: the reduced step is added and one modulus subtracted on overflow.
    always_comb
    begin
        knob_sum = {1'b0, knob_count_reg} + {1'b0, pbk_pkg::DELTA_MOD_TAB[s1_delta_reg]};
        if (knob_sum >= (pbk_pkg::COUNT_W + 1)'(pbk_pkg::COUNT_MODULUS))
        begin
            knob_sum = knob_sum - (pbk_pkg::COUNT_W + 1)'(pbk_pkg::COUNT_MODULUS);
        end
        knob_count_next = knob_count_reg;
        changed_next    = 1'b0;
        if (s1_mode_reg == pbk_pkg::MODE_ROTATION)
        begin
            knob_count_next = knob_sum[pbk_pkg::COUNT_W-1:0];
            changed_next    = (knob_count_next != knob_count_reg);
        end
    end

    // Triangle-wave brightness from the updated tick count.
    always_comb
    begin
        tick_shifted = tick_next >> shift_reg;
        phase        = tick_shifted[5:0];
        phase_dist   = phase[5] ? (phase - pbk_pkg::PHASE_MID) : (pbk_pkg::PHASE_MID - phase);
        priority if (phase_dist <= pbk_pkg::LOW_KNEE)
        begin
            brightness_next = pbk_pkg::BRIGHT_MIN;
        end
        else if (phase_dist >= pbk_pkg::HIGH_KNEE)
        begin
            brightness_next = pbk_pkg::BRIGHT_MAX;
        end
        else
        begin
            brightness_next = 4'(phase_dist - pbk_pkg::BRIGHT_OFFSET);
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg        <= pbk_pkg::SHIFT_RESET;
            history_reg      <= 4'd0;
            held_reg         <= 1'b0;
            switch_state_reg <= 1'b0;
            tick_reg         <= 32'd0;
            knob_count_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                shift_reg <= cfg_write_data;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg    <= 1'b1;
                history_reg      <= history_next;
                held_reg         <= held_next;
                switch_state_reg <= switch_state_next;
                tick_reg         <= tick_next;
                knob_count_reg   <= knob_count_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the two stages.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg  <= mode;
            s1_level_reg <= button_level;
            s1_delta_reg <= rotation_delta;
        end
        if (s1_fire)
        begin
            key_held_reg      <= held_next;
            press_event_reg   <= press_next;
            release_event_reg <= release_next;
            switch_on_reg     <= switch_state_next;
            brightness_reg    <= brightness_next;
            count_value_reg   <= knob_count_next;
            count_changed_reg <= changed_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_held      = key_held_reg;
    assign press_event   = press_event_reg;
    assign release_event = release_event_reg;
    assign switch_on     = switch_on_reg;
    assign brightness    = brightness_reg;
    assign count_value   = count_value_reg;
    assign count_changed = count_changed_reg;

    // The switch changes exactly when the loaded result reports a press.
    a_switch_follows_press: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> ((switch_state_reg != $past(switch_state_reg)) == press_event_reg))
        else $error("switch state change does not match press event");

    // The knob counter stays below the modulus.
    a_knob_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        knob_count_reg < pbk_pkg::COUNT_W'(pbk_pkg::COUNT_MODULUS))
        else $error("knob counter out of range");

    // A reported press always leaves the button held.
    a_press_sets_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && press_event_reg |-> key_held_reg)
        else $error("press reported without held flag");

    // The tick counter only moves when a request is loaded into the result register.
    a_tick_moves_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(tick_reg))
        else $error("tick counter moved without a request");

endmodule

`default_nettype wire

>>> tb/panel_button_knob_controller_tb.sv
// Self-checking testbench for the front-panel button and knob controller.
// Drives requests and breath rate writes, predicts every result in a small scoreboard
// class and checks each result in order. Depends on pbk_pkg and the controller RTL.
`timescale 1ns / 100ps
`default_nettype none

module panel_button_knob_controller_tb;

    // One result as the block presents it.
    typedef struct packed
    {
        logic            held;
        logic            press;
        logic            release_seen;
        logic            switch_state;
        logic [3:0]      bright;
        pbk_pkg::count_t knob;
        logic            knob_moved;
    } panel_result_t;

    // Keeps its own copy of the panel state, predicts the result of every accepted
    // request and checks the results against those predictions in order.
    class panel_scoreboard;
        logic [pbk_pkg::SHIFT_W-1:0] breath_shift;
        logic [3:0]                  history;
        logic                        held;
        logic                        switch_state;
        logic [31:0]                 ticks;
        pbk_pkg::count_t             knob;
        panel_result_t               expected_panels[$];
        int                          mismatches;

        function new();
            breath_shift = pbk_pkg::SHIFT_RESET;
            history      = 4'b0000;
            held         = 1'b0;
            switch_state = 1'b0;
            ticks        = 32'd0;
            knob         = '0;
            mismatches   = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function int pending();
            return expected_panels.size();
        endfunction

        function void set_shift(input logic [pbk_pkg::SHIFT_W-1:0] value);
            breath_shift = value;
        endfunction

        // Triangle wave over the shifted tick count, clamped to 1..15.
        function logic [3:0] breath_level(input logic [31:0] t,
                                          input logic [pbk_pkg::SHIFT_W-1:0] sh);
            int phase;
            int span;
            phase = int'((t >> sh) & 32'd63);
            span  = phase - 32;
            if (span < 0)
            begin
                span = -span;
            end
            span = span - 16;
            if (span > 7)
            begin
                span = 7;
            end
            if (span < -7)
            begin
                span = -7;
            end
            return 4'(span + 8);
        endfunction

        // Advance the panel state by one accepted request and queue its result.
        function void note_request(input logic m, input logic lvl,
                                   input logic signed [pbk_pkg::DELTA_W-1:0] step);
            panel_result_t   res;
            int              sum;
            int              delta;
            pbk_pkg::count_t prior;
            res = '0;
            if (m == pbk_pkg::MODE_TICK)
            begin
                history = {history[2:0], ~lvl};
                if (history == pbk_pkg::PRESS_PATTERN)
                begin
                    held         = 1'b1;
                    res.press    = 1'b1;
                    switch_state = ~switch_state;
                end
                else if (history == pbk_pkg::RELEASE_PATTERN)
                begin
                    held             = 1'b0;
                    res.release_seen = 1'b1;
                end
                ticks = ticks + 32'd1;
            end
            else
            begin
                delta = step;
                prior = knob;
                sum   = int'(knob) + delta;
                sum   = sum % pbk_pkg::COUNT_MODULUS;
                if (sum < 0)
                begin
                    sum = sum + pbk_pkg::COUNT_MODULUS;
                end
                knob           = pbk_pkg::count_t'(sum);
                res.knob_moved = (knob != prior);
            end
            res.held         = held;
            res.switch_state = switch_state;
            res.bright       = breath_level(ticks, breath_shift);
            res.knob         = knob;
            expected_panels.push_back(res);
        endfunction

        task compare_field(input string name, input int got, input int want);
            if (got != want)
            begin
                report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
            end
        endtask

        // Compare one accepted result with the oldest prediction.
        task check_result(input panel_result_t got);
            panel_result_t want;
            if (expected_panels.size() == 0)
            begin
                report_mismatch("result arrived with no request outstanding");
            end
            else
            begin
                want = expected_panels.pop_front();
                compare_field("key_held", got.held, want.held);
                compare_field("press_event", got.press, want.press);
                compare_field("release_event", got.release_seen, want.release_seen);
                compare_field("switch_on", got.switch_state, want.switch_state);
                compare_field("brightness", got.bright, want.bright);
                compare_field("count_value", got.knob, want.knob);
                compare_field("count_changed", got.knob_moved, want.knob_moved);
            end
        endtask
    endclass

    logic                               clk            = 1'b0;
    logic                               rst_n          = 1'b0;
    logic                               cfg_write_en   = 1'b0;
    logic [pbk_pkg::SHIFT_W-1:0]        cfg_write_data = '0;
    logic                               in_valid       = 1'b0;
    logic                               in_stall;
    logic                               mode           = pbk_pkg::MODE_TICK;
    logic                               button_level   = 1'b1;
    logic signed [pbk_pkg::DELTA_W-1:0] rotation_delta = '0;
    logic                               out_valid;
    logic                               out_stall      = 1'b0;
    logic                               key_held;
    logic                               press_event;
    logic                               release_event;
    logic                               switch_on;
    logic [3:0]                         brightness;
    pbk_pkg::count_t                    count_value;
    logic                               count_changed;

    int              send_idle_pct = 29;
    int              recv_idle_pct = 47;
    logic            long_hold     = 1'b0;
    logic            panel_key     = 1'b1;
    panel_scoreboard sb            = new();

    panel_button_knob_controller u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .button_level   (button_level),
        .rotation_delta (rotation_delta),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .key_held       (key_held),
        .press_event    (press_event),
        .release_event  (release_event),
        .switch_on      (switch_on),
        .brightness     (brightness),
        .count_value    (count_value),
        .count_changed  (count_changed)
    );

    always #2 clk = ~clk;

    // Result side: choose the stall at the falling edge, take results at the rising edge.
    always
    begin
        @(negedge clk);
        out_stall = long_hold || ($urandom_range(99) < recv_idle_pct);
        @(posedge clk);
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result('{key_held, press_event, release_event, switch_on,
                              brightness, count_value, count_changed});
        end
    end

    // Offer one request, with an optional gap first, and wait until it is accepted.
    // Entered and left at a falling edge.
    task automatic send_request(input logic m, input logic lvl,
                                input logic signed [pbk_pkg::DELTA_W-1:0] step);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        mode           = m;
        button_level   = lvl;
        rotation_delta = step;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_request(m, lvl, step);
        @(negedge clk);
    endtask

    // Random requests: mostly ticks whose button level is held in runs, so that press and
    // release patterns occur often, with some noisy samples and knob steps mixed in.
    task automatic send_random(input int count);
        logic                               lvl;
        logic signed [pbk_pkg::DELTA_W-1:0] step;
        for (int i = 0; i < count; i++)
        begin
            step = pbk_pkg::DELTA_W'($urandom());
            lvl  = 1'($urandom());
            if ($urandom_range(99) < 30)
            begin
                send_request(pbk_pkg::MODE_ROTATION, lvl, step);
            end
            else
            begin
                if ($urandom_range(99) >= 15)
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        panel_key = ~panel_key;
                    end
                    lvl = panel_key;
                end
                send_request(pbk_pkg::MODE_TICK, lvl, step);
            end
        end
    endtask

    // Stop offering requests until every predicted result has come, then let the
    // pipeline settle.
    task automatic wait_for_results();
        int spin;
        spin     = 0;
        in_valid = 1'b0;
        while (sb.pending() != 0 && spin < 5000)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (4) @(negedge clk);
    endtask

    // Write the breath rate shift while the block is idle.
    task automatic write_breath_shift(input logic [pbk_pkg::SHIFT_W-1:0] value);
        cfg_write_en   = 1'b1;
        cfg_write_data = value;
        @(negedge clk);
        cfg_write_en = 1'b0;
        sb.set_shift(value);
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed requests at the reset shift: knob wrap both ways, a zero step, ignored
        // fields, and a clean press followed by a clean release.
        send_request(pbk_pkg::MODE_ROTATION, 1'b0, -5'sd16);
        send_request(pbk_pkg::MODE_ROTATION, 1'b1, 5'sd15);
        send_request(pbk_pkg::MODE_ROTATION, 1'b0, 5'sd1);
        send_request(pbk_pkg::MODE_ROTATION, 1'b1, 5'sd0);
        send_request(pbk_pkg::MODE_ROTATION, 1'b0, -5'sd1);
        send_request(pbk_pkg::MODE_ROTATION, 1'b1, 5'sd1);
        send_request(pbk_pkg::MODE_TICK, 1'b0, 5'sd15);
        send_request(pbk_pkg::MODE_TICK, 1'b0, -5'sd16);
        send_request(pbk_pkg::MODE_TICK, 1'b0, 5'sd0);
        send_request(pbk_pkg::MODE_ROTATION, 1'b0, -5'sd16);
        send_request(pbk_pkg::MODE_TICK, 1'b0, 5'sd7);
        send_request(pbk_pkg::MODE_TICK, 1'b1, -5'sd1);
        send_request(pbk_pkg::MODE_TICK, 1'b1, 5'sd0);
        send_request(pbk_pkg::MODE_TICK, 1'b1, 5'sd0);
        send_request(pbk_pkg::MODE_TICK, 1'b1, 5'sd0);
        send_request(pbk_pkg::MODE_TICK, 1'b0, 5'sd0);
        send_request(pbk_pkg::MODE_TICK, 1'b0, 5'sd0);
        send_request(pbk_pkg::MODE_TICK, 1'b0, 5'sd0);
        send_request(pbk_pkg::MODE_TICK, 1'b0, 5'sd0);
        send_request(pbk_pkg::MODE_ROTATION, 1'b1, 5'sd15);
        send_request(pbk_pkg::MODE_TICK, 1'b1, 5'sd0);
        send_request(pbk_pkg::MODE_TICK, 1'b0, 5'sd0);
        send_request(pbk_pkg::MODE_TICK, 1'b1, 5'sd0);
        wait_for_results();

        // Fastest breathing, sender idling less than the receiver.
        write_breath_shift(5'd0);
        send_random(450);
        wait_for_results();

        // Shift past the useful range, idling the other way round, with one long hold on
        // the result side while requests keep coming.
        write_breath_shift(5'd31);
        send_idle_pct = 47;
        recv_idle_pct = 29;
        send_random(225);
        fork
            begin
                long_hold = 1'b1;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
        join_none
        send_idle_pct = 0;
        send_random(100);
        wait_for_results();

        write_breath_shift(5'd3);
        send_idle_pct = 47;
        send_random(225);
        wait_for_results();

        // Upper end of the useful range, then a random shift, with no idling at all.
        write_breath_shift(5'd25);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(300);
        wait_for_results();

        write_breath_shift(pbk_pkg::SHIFT_W'($urandom_range(0, 7)));
        send_random(50);
        wait_for_results();

        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d predicted results never arrived", sb.pending()));
        end
        if (sb.mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
